// ----- rtl/core/mcc_pkg.sv -----
`default_nettype none

package mcc_pkg;

   // Command codes of an input item
   typedef enum logic [1:0] {
      CMD_MS_TICK    = 2'd0,
      CMD_SLEEP_TICK = 2'd1,
      CMD_SET        = 2'd2,
      CMD_ELAPSED    = 2'd3
   } cmd_type;

   // Calendar field selected by a set command
   typedef enum logic [2:0] {
      COMP_YEAR   = 3'd0,
      COMP_MONTH  = 3'd1,
      COMP_DAY    = 3'd2,
      COMP_HOUR   = 3'd3,
      COMP_MINUTE = 3'd4
   } comp_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_SLEEP_STEP = 2'd0;
   localparam logic [1:0] CSR_WRAP_FIX   = 2'd1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Reset values of the calendar and configuration
   localparam logic [9:0]  SLEEP_STEP_RST = 10'd16;
   localparam logic [15:0] WRAP_FIX_RST   = 16'd296;
   localparam logic [7:0]  YEAR_OFS_RST   = 8'd22;
   localparam logic [3:0]  MONTH_RST      = 4'd12;
   localparam logic [4:0]  DAY_RST        = 5'd7;

   localparam logic [11:0] YEAR_BASE      = 12'd2000;
   // 2000 mod 256, subtracted from a full year to get the offset
   localparam logic [7:0]  YEAR_BASE_LOW  = 8'd208;
   // 1000 - (2^32 mod 1000): added to the remainder when the count wraps
   localparam logic [11:0] WRAP_REM_ADJ   = 12'd704;

   typedef struct packed {
      logic [9:0]  sleep_step;
      logic [15:0] wrap_fix;
      logic [9:0]  wrap_rem;    // wrap_fix mod 1000
   } cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      comp_type    component;
      logic [15:0] set_value;
      logic [31:0] base_ms;
      logic [31:0] until_ms;    // base + delta, wrap fix already applied
      logic        until_wrap;  // base + delta carried out of 32 bits
   } item_type;

   typedef struct packed {
      logic [11:0] year_full;
      logic [3:0]  month_now;
      logic [4:0]  day_now;
      logic [4:0]  hour_now;
      logic [5:0]  minute_now;
      logic [5:0]  second_now;
      logic [31:0] millis_now;
      logic        second_event;
      logic        minute_event;
      logic        hourly_save;
      logic        wrap_event;
      logic        elapsed;
   } result_type;

   // Gregorian leap test for years 2000..2255 given as an offset from 2000
   function automatic logic is_leap(input logic [7:0] year_ofs);
      return (year_ofs[1:0] == 2'd0) && (year_ofs != 8'd100) && (year_ofs != 8'd200);
   endfunction

   // Days in a month; anything out of range counts as 31
   function automatic logic [4:0] month_days(input logic [3:0] month,
                                             input logic [7:0] year_ofs);
      logic [4:0] days;
      case (month)
         4'd2:    days = is_leap(year_ofs) ? 5'd29 : 5'd28;
         4'd4:    days = 5'd30;
         4'd6:    days = 5'd30;
         4'd9:    days = 5'd30;
         4'd11:   days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

   // Remainder by 1000 of a 16-bit value, restoring subtraction of 1000 << k
   function automatic logic [9:0] mod1000_16(input logic [15:0] x);
      logic [15:0] r;
      r = x;
      for (int k = 6; k >= 0; k--) begin
         if (r >= (16'd1000 << k)) begin
            r = r - (16'd1000 << k);
         end
      end
      return r[9:0];
   endfunction

   // Remainder by 1000 of a value below 4000
   function automatic logic [9:0] red1000_12(input logic [11:0] x);
      logic [11:0] r;
      if (x >= 12'd3000) begin
         r = x - 12'd3000;
      end else if (x >= 12'd2000) begin
         r = x - 12'd2000;
      end else if (x >= 12'd1000) begin
         r = x - 12'd1000;
      end else begin
         r = x;
      end
      return r[9:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mcc_csr.sv -----
`default_nettype none

module mcc_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [mcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mcc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output mcc_pkg::cfg_type                     cfg
);
   import mcc_pkg::*;

   logic [9:0]  sleep_step_ff;
   logic [15:0] wrap_fix_ff;
   logic [9:0]  wrap_rem_ff;

   // Write registers; keep the wrap fix remainder alongside the wrap fix
   always_ff @(posedge clock) begin
      if (reset) begin
         sleep_step_ff <= SLEEP_STEP_RST;
         wrap_fix_ff   <= WRAP_FIX_RST;
         wrap_rem_ff   <= mod1000_16(WRAP_FIX_RST);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLEEP_STEP: sleep_step_ff <= csr_wdata[9:0];
            CSR_WRAP_FIX: begin
               wrap_fix_ff <= csr_wdata;
               wrap_rem_ff <= mod1000_16(csr_wdata);
            end
            default: ;
         endcase
      end
   end

   assign cfg.sleep_step = sleep_step_ff;
   assign cfg.wrap_fix   = wrap_fix_ff;
   assign cfg.wrap_rem   = wrap_rem_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mcc_time.sv -----
`default_nettype none

module mcc_time (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire mcc_pkg::item_type item,
   input  wire mcc_pkg::cfg_type  cfg,
   output mcc_pkg::result_type    result
);
   import mcc_pkg::*;

   // Time state; rem tracks millis mod 1000
   logic [31:0] millis_ff, millis_in;
   logic [9:0]  rem_ff, rem_in;
   logic [7:0]  year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;

   logic [32:0] tick_sum;
   logic [32:0] sleep_sum;
   logic [31:0] sleep_fix_sum;
   logic        sleep_wrap;
   logic [11:0] sleep_rsum;

   logic [5:0]  adv_sec, adv_min, adv_day;
   logic [4:0]  adv_hour;
   logic [3:0]  adv_month;
   logic [7:0]  adv_year;

   logic [7:0]  set_byte;
   logic [3:0]  set_month;
   logic [4:0]  set_month_days;
   logic [4:0]  cur_month_days;

   logic sec_ev, min_ev, save, wrap, el;

   // Count arithmetic for both tick kinds
   assign tick_sum      = {1'b0, millis_ff} + 33'd1;
   assign sleep_sum     = {1'b0, millis_ff} + {23'd0, cfg.sleep_step};
   assign sleep_fix_sum = millis_ff + {22'd0, cfg.sleep_step} + {16'd0, cfg.wrap_fix};
   assign sleep_wrap    = sleep_sum[32];
   assign sleep_rsum    = {2'd0, rem_ff} + {2'd0, cfg.sleep_step}
                        + (sleep_wrap ? ({2'd0, cfg.wrap_rem} + WRAP_REM_ADJ) : 12'd0);

   // Advance the calendar by one second, cascading the rollovers
   always_comb begin
      adv_sec   = second_ff + 6'd1;
      adv_min   = minute_ff;
      adv_hour  = hour_ff;
      adv_day   = {1'b0, day_ff};
      adv_month = month_ff;
      adv_year  = year_ff;
      if (adv_sec >= 6'd60) begin
         adv_sec = 6'd0;
         adv_min = adv_min + 6'd1;
      end
      if (adv_min >= 6'd60) begin
         adv_min  = 6'd0;
         adv_hour = adv_hour + 5'd1;
      end
      if (adv_hour >= 5'd24) begin
         adv_hour = 5'd0;
         adv_day  = adv_day + 6'd1;
      end
      if (adv_day > {1'b0, month_days(adv_month, adv_year)}) begin
         adv_day   = 6'd1;
         adv_month = adv_month + 4'd1;
      end
      if (adv_month > 4'd12) begin
         adv_month = 4'd1;
         adv_year  = adv_year + 8'd1;
      end
   end

   // Clamp values for a set command
   assign set_byte       = item.set_value[7:0];
   assign set_month      = (set_byte > 8'd12) ? 4'd12 :
                           (set_byte == 8'd0) ? 4'd1 : set_byte[3:0];
   assign set_month_days = month_days(set_month, year_ff);
   assign cur_month_days = month_days(month_ff, year_ff);

   // Next state and event flags for the item in the input register
   always_comb begin
      millis_in = millis_ff;
      rem_in    = rem_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      sec_ev    = 1'b0;
      save      = 1'b0;
      wrap      = 1'b0;
      el        = 1'b0;
      case (item.cmd)
         CMD_MS_TICK: begin
            wrap      = tick_sum[32];
            millis_in = tick_sum[32] ? {16'd0, cfg.wrap_fix} : tick_sum[31:0];
            rem_in    = tick_sum[32] ? cfg.wrap_rem :
                        (rem_ff == 10'd999) ? 10'd0 : rem_ff + 10'd1;
            sec_ev    = (rem_in == 10'd0);
         end
         CMD_SLEEP_TICK: begin
            millis_in = sleep_wrap ? sleep_fix_sum : sleep_sum[31:0];
            rem_in    = red1000_12(sleep_rsum);
            sec_ev    = sleep_wrap || (sleep_rsum >= 12'd1000);
         end
         CMD_SET: begin
            save = 1'b1;
            case (item.component)
               COMP_YEAR:   year_in = set_byte - YEAR_BASE_LOW;
               COMP_MONTH: begin
                  month_in = set_month;
                  day_in   = (day_ff > set_month_days) ? set_month_days : day_ff;
               end
               COMP_DAY: begin
                  day_in = (set_byte > {3'd0, cur_month_days}) ? cur_month_days :
                           (set_byte == 8'd0) ? 5'd1 : set_byte[4:0];
               end
               COMP_HOUR:   hour_in = (set_byte > 8'd23) ? 5'd23 : set_byte[4:0];
               COMP_MINUTE: minute_in = (set_byte > 8'd59) ? 6'd59 : set_byte[5:0];
               default: ;
            endcase
         end
         CMD_ELAPSED: begin
            el = item.until_wrap ?
                 ((millis_ff < item.base_ms) && (millis_ff >= item.until_ms)) :
                 (millis_ff >= item.until_ms);
         end
         default: ;
      endcase
      if (sec_ev) begin
         second_in = adv_sec;
         minute_in = adv_min;
         hour_in   = adv_hour;
         day_in    = adv_day[4:0];
         month_in  = adv_month;
         year_in   = adv_year;
         if ((adv_sec == 6'd0) && (adv_min == 6'd0)) begin
            save = 1'b1;
         end
      end
   end

   assign min_ev = sec_ev && (adv_sec == 6'd0);

   // Commit the state when the item moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         millis_ff <= 32'd0;
         rem_ff    <= 10'd0;
         year_ff   <= YEAR_OFS_RST;
         month_ff  <= MONTH_RST;
         day_ff    <= DAY_RST;
         hour_ff   <= 5'd0;
         minute_ff <= 6'd0;
         second_ff <= 6'd0;
      end else if (fire) begin
         millis_ff <= millis_in;
         rem_ff    <= rem_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
      end
   end

   // Report the time after this item
   assign result.year_full    = YEAR_BASE + {4'd0, year_in};
   assign result.month_now    = month_in;
   assign result.day_now      = day_in;
   assign result.hour_now     = hour_in;
   assign result.minute_now   = minute_in;
   assign result.second_now   = second_in;
   assign result.millis_now   = millis_in;
   assign result.second_event = sec_ev;
   assign result.minute_event = min_ev;
   assign result.hourly_save  = save;
   assign result.wrap_event   = wrap;
   assign result.elapsed      = el;

endmodule

`default_nettype wire

// ----- rtl/core/millisecond_calendar_clock.sv -----
`default_nettype none

// Millisecond counter with a Gregorian calendar (years 2000..2255). Each item
// (ms tick, sleep tick, set field, elapsed query) returns one result with the
// time after the item and its event flags. One item can be taken every clock
// cycle while rsp_stall is low. The edge that accepts an item loads the input
// register; the item then passes through the combinational time update into
// the result register, which loads once it is empty or rsp_stall is low.
// While a result waits under rsp_stall, the input register takes at most one
// more item; after that rsp_stall reaches req_stall in the same cycle.
// Configuration: index 0 is the sleep step in ms (10 bits), index 1 the wrap
// fix in ms (16 bits); write them only while no item is in flight.
module millisecond_calendar_clock (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input items
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [2:0]                      req_component,
   input  wire logic [15:0]                     req_set_value,
   input  wire logic [31:0]                     req_base_ms,
   input  wire logic [31:0]                     req_delta_ms,
   // result items
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [11:0]                     rsp_year_full,
   output      logic [3:0]                      rsp_month_now,
   output      logic [4:0]                      rsp_day_now,
   output      logic [4:0]                      rsp_hour_now,
   output      logic [5:0]                      rsp_minute_now,
   output      logic [5:0]                      rsp_second_now,
   output      logic [31:0]                     rsp_millis_now,
   output      logic                            rsp_second_event,
   output      logic                            rsp_minute_event,
   output      logic                            rsp_hourly_save,
   output      logic                            rsp_wrap_event,
   output      logic                            rsp_elapsed,
   // configuration writes
   input  wire logic                            csr_we,
   input  wire logic [mcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mcc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mcc_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   result_type result;
   result_type rsp_ff;

   logic        in_valid_ff, in_valid_in;
   logic        out_valid_ff, out_valid_in;
   logic        take;
   logic        fire;
   logic [32:0] until_sum;
   logic [31:0] until_fix;

   mcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mcc_time u_time (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Handshake: the input stage moves on when the result register is free
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   // Form the query deadline on the way in
   assign until_sum = {1'b0, req_base_ms} + {1'b0, req_delta_ms};
   assign until_fix = req_base_ms + req_delta_ms + {16'd0, cfg.wrap_fix};

   always_comb begin
      item_in.cmd        = cmd_type'(req_cmd);
      item_in.component  = comp_type'(req_component);
      item_in.set_value  = req_set_value;
      item_in.base_ms    = req_base_ms;
      item_in.until_ms   = until_sum[32] ? until_fix : until_sum[31:0];
      item_in.until_wrap = until_sum[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payloads until they move on
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_year_full    = rsp_ff.year_full;
   assign rsp_month_now    = rsp_ff.month_now;
   assign rsp_day_now      = rsp_ff.day_now;
   assign rsp_hour_now     = rsp_ff.hour_now;
   assign rsp_minute_now   = rsp_ff.minute_now;
   assign rsp_second_now   = rsp_ff.second_now;
   assign rsp_millis_now   = rsp_ff.millis_now;
   assign rsp_second_event = rsp_ff.second_event;
   assign rsp_minute_event = rsp_ff.minute_event;
   assign rsp_hourly_save  = rsp_ff.hourly_save;
   assign rsp_wrap_event   = rsp_ff.wrap_event;
   assign rsp_elapsed      = rsp_ff.elapsed;

endmodule

`default_nettype wire

// ----- tb/sv/tb_millisecond_calendar_clock.sv -----
`timescale 1ns / 1ps

module tb_millisecond_calendar_clock;
   import mcc_pkg::*;

   // Register indexes that the block has no register behind
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;

   // Predict the time and flags after each item and compare with what comes out
   class calendar_scoreboard;
      int unsigned sleep_step, wrap_fix;
      int unsigned millis, year_ofs, month, day, hour, minute, second;
      result_type expected_q[$];
      int n_items, n_results, n_errors;
      int n_seconds, n_minutes, n_year_wraps, n_queries, n_hits;

      function new();
         sleep_step = SLEEP_STEP_RST;
         wrap_fix   = WRAP_FIX_RST;
         millis     = 0;
         year_ofs   = YEAR_OFS_RST;
         month      = MONTH_RST;
         day        = DAY_RST;
         hour       = 0;
         minute     = 0;
         second     = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         if (idx == CSR_SLEEP_STEP) begin
            sleep_step = data[9:0];
         end else if (idx == CSR_WRAP_FIX) begin
            wrap_fix = data;
         end
      endfunction

      function int unsigned days_in_month();
         int unsigned y;
         y = 2000 + year_ofs;
         case (month)
            2: begin
               return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
            end
            4, 6, 9, 11: return 30;
            default: return 31;
         endcase
      endfunction

      // Roll the calendar forward by one second, cascading upward
      function void advance_second();
         second++;
         if (second >= 60) begin
            second = 0;
            minute++;
         end
         if (minute >= 60) begin
            minute = 0;
            hour++;
         end
         if (hour >= 24) begin
            hour = 0;
            day++;
         end
         if (day > days_in_month()) begin
            day = 1;
            month++;
         end
         if (month > 12) begin
            month = 1;
            year_ofs = (year_ofs + 1) & 255;
            if (year_ofs == 0) n_year_wraps++;
         end
      endfunction

      // Write one calendar field; the year wraps, the rest are clamped
      function void apply_set(logic [2:0] comp, logic [15:0] value);
         int unsigned b, lim;
         b = value[7:0];
         case (comp)
            COMP_YEAR: year_ofs = (value - 2000) & 255;
            COMP_MONTH: begin
               month = (b > 12) ? 12 : ((b == 0) ? 1 : b);
               lim = days_in_month();
               if (day > lim) day = lim;
            end
            COMP_DAY: begin
               lim = days_in_month();
               day = (b > lim) ? lim : ((b == 0) ? 1 : b);
            end
            COMP_HOUR: hour = (b > 23) ? 23 : b;
            COMP_MINUTE: minute = (b > 59) ? 59 : b;
            default: ;
         endcase
      endfunction

      function void note_item(cmd_type cmd, logic [2:0] comp, logic [15:0] value,
                              logic [31:0] base, logic [31:0] delta);
         int unsigned old, until_ms;
         bit sec_ev = 1'b0;
         bit save = 1'b0;
         bit wrap = 1'b0;
         bit hit = 1'b0;
         result_type r;
         case (cmd)
            CMD_MS_TICK: begin
               millis = millis + 1;
               if (millis == 0) begin
                  millis = wrap_fix;
                  wrap = 1'b1;
               end
               sec_ev = (millis % 1000 == 0);
            end
            CMD_SLEEP_TICK: begin
               old = millis;
               millis = old + sleep_step;
               if (millis < old) millis = millis + wrap_fix;
               sec_ev = (millis / 1000 != old / 1000);
            end
            CMD_SET: begin
               apply_set(comp, value);
               save = 1'b1;
            end
            CMD_ELAPSED: begin
               until_ms = base + delta;
               if (until_ms < base) begin
                  until_ms = until_ms + wrap_fix;
                  hit = (millis < base) && (millis >= until_ms);
               end else begin
                  hit = (millis >= until_ms);
               end
               n_queries++;
               if (hit) n_hits++;
            end
            default: ;
         endcase
         if (sec_ev) begin
            advance_second();
            n_seconds++;
         end
         r.year_full    = 12'(2000 + year_ofs);
         r.month_now    = 4'(month);
         r.day_now      = 5'(day);
         r.hour_now     = 5'(hour);
         r.minute_now   = 6'(minute);
         r.second_now   = 6'(second);
         r.millis_now   = millis;
         r.second_event = sec_ev;
         r.minute_event = sec_ev && second == 0;
         r.hourly_save  = save || (sec_ev && second == 0 && minute == 0);
         r.wrap_event   = wrap;
         r.elapsed      = hit;
         if (r.minute_event) n_minutes++;
         expected_q.push_back(r);
         n_items++;
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            n_errors++;
            if (n_errors <= 10) begin
               $display("result %0d: %s expected %0d, got %0d", n_results, name, want, got);
            end
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         n_results++;
         if (expected_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("result %0d arrived with no item outstanding", n_results);
            return;
         end
         want = expected_q.pop_front();
         check_field("year_full", want.year_full, got.year_full);
         check_field("month_now", want.month_now, got.month_now);
         check_field("day_now", want.day_now, got.day_now);
         check_field("hour_now", want.hour_now, got.hour_now);
         check_field("minute_now", want.minute_now, got.minute_now);
         check_field("second_now", want.second_now, got.second_now);
         check_field("millis_now", want.millis_now, got.millis_now);
         check_field("second_event", want.second_event, got.second_event);
         check_field("minute_event", want.minute_event, got.minute_event);
         check_field("hourly_save", want.hourly_save, got.hourly_save);
         check_field("wrap_event", want.wrap_event, got.wrap_event);
         check_field("elapsed", want.elapsed, got.elapsed);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [2:0]  req_component = '0;
   logic [15:0] req_set_value = '0;
   logic [31:0] req_base_ms = '0;
   logic [31:0] req_delta_ms = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_year_full;
   logic [3:0]  rsp_month_now;
   logic [4:0]  rsp_day_now;
   logic [4:0]  rsp_hour_now;
   logic [5:0]  rsp_minute_now;
   logic [5:0]  rsp_second_now;
   logic [31:0] rsp_millis_now;
   logic        rsp_second_event;
   logic        rsp_minute_event;
   logic        rsp_hourly_save;
   logic        rsp_wrap_event;
   logic        rsp_elapsed;

   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   result_type seen;
   calendar_scoreboard sb;
   int idle_pct = 0;
   int stall_pct = 0;
   bit primed = 1'b0;

   millisecond_calendar_clock dut (.*);

   assign seen = {rsp_year_full, rsp_month_now, rsp_day_now, rsp_hour_now, rsp_minute_now,
                  rsp_second_now, rsp_millis_now, rsp_second_event, rsp_minute_event,
                  rsp_hourly_save, rsp_wrap_event, rsp_elapsed};

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Note accepted items and check accepted results
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_item(cmd_type'(req_cmd), req_component, req_set_value, req_base_ms,
                      req_delta_ms);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(seen);
      end
   end

   // Offer one item after an optional idle gap and hold it until taken
   task automatic send_item(cmd_type cmd, logic [2:0] comp, logic [15:0] value,
                            logic [31:0] base, logic [31:0] delta);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_component <= comp;
      req_set_value <= value;
      req_base_ms   <= base;
      req_delta_ms  <= delta;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering, then wait until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register; the caller drops the write enable afterward
   task automatic csr_put(logic [1:0] idx, logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic configure(logic [15:0] step_data, logic [15:0] fix_data);
      csr_put(CSR_SPARE_2, 16'($urandom));
      csr_put(CSR_SLEEP_STEP, step_data);
      csr_put(CSR_WRAP_FIX, fix_data);
      csr_put(CSR_SPARE_3, 16'($urandom));
      csr_we <= 1'b0;
   endtask

   // Park the count just below a whole second, then let a ms tick cross it
   task automatic hit_ms_boundary();
      int unsigned r;
      r = sb.millis % 1000;
      csr_put(CSR_SLEEP_STEP, (r == 999) ? 16'd1000 : 16'(999 - r));
      csr_we <= 1'b0;
      send_item(CMD_SLEEP_TICK, 3'($urandom), 16'($urandom), $urandom, $urandom);
      send_item(CMD_MS_TICK, 3'($urandom), 16'($urandom), $urandom, $urandom);
   endtask

   // Move the calendar to the edge of a minute, hour, day, month or year
   task automatic prime_rollover();
      int unsigned yr;
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 4))
            0: yr = 2255;
            1: yr = 2024;
            2: yr = 2100;
            3: yr = 2000;
            default: yr = 2000 + $urandom_range(0, 255);
         endcase
         send_item(CMD_SET, COMP_YEAR, 16'(yr), $urandom, $urandom);
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 3))
            0: yr = 12;
            1, 2: yr = 2;
            default: yr = $urandom_range(1, 12);
         endcase
         send_item(CMD_SET, COMP_MONTH, 16'(yr), $urandom, $urandom);
      end
      if ($urandom_range(0, 3) != 0) send_item(CMD_SET, COMP_DAY, 16'd31, $urandom, $urandom);
      if ($urandom_range(0, 3) != 0) send_item(CMD_SET, COMP_HOUR, 16'd23, $urandom, $urandom);
      if ($urandom_range(0, 6) != 0) begin
         send_item(CMD_SET, COMP_MINUTE, 16'd59, $urandom, $urandom);
      end
   endtask

   task automatic send_random();
      int unsigned pick, cnt, sleep_w, ms_end, set_end, val;
      logic [31:0] base, delta;
      cnt = sb.millis;
      if (sb.second < 58) begin
         primed = 1'b0;
      end else if (!primed) begin
         primed = 1'b1;
         prime_rollover();
      end
      sleep_w = (sb.sleep_step >= 500) ? 65 : 30;
      ms_end  = sleep_w + ((sleep_w == 65) ? 15 : 35);
      set_end = ms_end + 10;
      pick    = $urandom_range(0, 99);
      if ((cnt % 1000 >= 990 && pick < 70) || (pick >= sleep_w && pick < ms_end)) begin
         send_item(CMD_MS_TICK, 3'($urandom), 16'($urandom), $urandom, $urandom);
      end else if (pick < sleep_w) begin
         send_item(CMD_SLEEP_TICK, 3'($urandom), 16'($urandom), $urandom, $urandom);
      end else if (pick < set_end) begin
         case ($urandom_range(0, 2))
            0: val = $urandom;
            1: val = $urandom_range(0, 35);
            default: val = 2000 + $urandom_range(0, 260);
         endcase
         send_item(CMD_SET, 3'($urandom_range(0, 7)), 16'(val), $urandom, $urandom);
      end else begin
         case ($urandom_range(0, 4))
            0, 1: begin
               base  = cnt - $urandom_range(0, 2000);
               delta = $urandom_range(0, 4000);
            end
            2: begin
               base  = 32'hFFFF_FFFF - $urandom_range(0, 3000);
               delta = $urandom_range(0, 70000);
            end
            3: begin
               base  = $urandom;
               delta = $urandom;
            end
            default: begin
               base  = $urandom;
               delta = 32'hFFFF_FFFF - $urandom_range(0, 70000);
            end
         endcase
         send_item(CMD_ELAPSED, 3'($urandom), 16'($urandom), base, delta);
      end
   endtask

   initial begin
      logic [15:0] step_tab [8];
      logic [15:0] fix_tab [8];
      int mode;
      sb = new();
      step_tab = '{16'd1000, 16'd1, 16'd999, 16'hFC00, 16'd1000, 16'd500, 16'hF3E8,
                   16'($urandom_range(1, 1000))};
      fix_tab  = '{16'd0, 16'hFFFF, 16'd296, 16'd1234, 16'hFFFF, 16'd0, 16'($urandom),
                   16'($urandom)};

      // Hold reset, then release it
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset settings
      send_item(CMD_MS_TICK, 3'd0, 16'd0, 32'd0, 32'd0);
      send_item(CMD_SLEEP_TICK, 3'd0, 16'd0, 32'd0, 32'd0);
      send_item(CMD_ELAPSED, 3'd0, 16'd0, 32'd0, 32'd0);
      send_item(CMD_ELAPSED, 3'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_ELAPSED, 3'd0, 16'd0, 32'd0, 32'hFFFF_FFFF);
      send_item(CMD_ELAPSED, 3'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FED9);
      send_item(CMD_ELAPSED, 3'd0, 16'd0, 32'd17, 32'd0);
      send_item(CMD_SET, COMP_YEAR, 16'd0, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_YEAR, 16'hFFFF, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_YEAR, 16'd2255, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_MONTH, 16'd0, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_MONTH, 16'hFFFF, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_MONTH, 16'd2, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_DAY, 16'd31, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_DAY, 16'd0, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_YEAR, 16'd2000, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_DAY, 16'h011D, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_YEAR, 16'd2100, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_MONTH, 16'd2, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_HOUR, 16'hFFFF, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_HOUR, 16'd0, 32'd0, 32'd0);
      send_item(CMD_SET, COMP_MINUTE, 16'h3C3B, 32'd0, 32'd0);
      send_item(CMD_SET, 3'd5, 16'd0, 32'd0, 32'd0);
      send_item(CMD_SET, 3'd7, 16'hFFFF, 32'd0, 32'd0);
      send_item(CMD_SLEEP_TICK, 3'd0, 16'd0, 32'd0, 32'd0);
      drain();

      // Random phases: each handshake mode under two register settings
      for (int p = 0; p < 8; p++) begin
         mode      = p % 4;
         idle_pct  = (mode == 1) ? 80 : ((mode == 3) ? 8 : 0);
         stall_pct = (mode == 2) ? 80 : ((mode == 3) ? 8 : 0);
         hit_ms_boundary();
         drain();
         configure(step_tab[p], fix_tab[p]);
         repeat (62) send_random();
         drain();
      end

      $display("%0d items, %0d second steps, %0d minute and %0d year rollovers",
               sb.n_items, sb.n_seconds, sb.n_minutes, sb.n_year_wraps);
      $display("%0d elapsed queries (%0d true), %0d results checked, %0d mismatches",
               sb.n_queries, sb.n_hits, sb.n_results, sb.n_errors);
      if (sb.n_errors == 0) begin
         $display("[millisecond_calendar_clock] OK");
      end else begin
         $display("[millisecond_calendar_clock] ERROR");
      end
      $finish;
   end

   // Bound the run
   initial begin
      #2_000_000;
      $display("run did not finish in time, %0d results outstanding", sb.pending());
      $display("[millisecond_calendar_clock] ERROR");
      $finish;
   end

endmodule
